// ===== sv/sbwp_pkg.sv =====
// Shared types and constants for the sorted book weighted probe.
// Used by every module of the block; depends on nothing else.
package sbwp_pkg;

    localparam int BOOK_DEPTH = 4096;
    localparam int MAX_RUN    = 64;

    localparam int IDX_W    = $clog2(BOOK_DEPTH);
    localparam int SIZE_W   = $clog2(BOOK_DEPTH + 1);
    localparam int KEY_W    = 64;
    localparam int MOVE_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int RND_W    = 32;
    localparam int RUN_W    = $clog2(MAX_RUN + 1);
    localparam int SUM_W    = WEIGHT_W + RUN_W;
    localparam int STEP_W   = $clog2(RND_W);
    localparam int CFG_W    = 13;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PROBE = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [MOVE_W-1:0]   move;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_ram_wr;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_ram_rd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_SCAN,
        ST_SCAN_CMP,
        ST_MOD,
        ST_PICK,
        ST_PICK_CMP,
        ST_FIRST,
        ST_FIRST_CMP
    } t_state;

endpackage

// ===== sv/sbwp_book_ram.sv =====
// Book table storage: one synchronous RAM word per entry (key, move, weight).
// One write port and one read port with registered read data; uses sbwp_pkg.
module sbwp_book_ram
    import sbwp_pkg::*;
(
    input  logic    i_clk,
    input  t_ram_wr i_wr,
    input  t_ram_rd i_rd,
    output t_entry  o_rd_data
);

    t_entry r_mem [BOOK_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sbwp_mod_unit.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Computes dividend mod divisor for a nonzero divisor; uses sbwp_pkg.
module sbwp_mod_unit
    import sbwp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [SUM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [SUM_W-1:0] o_rem
);

    logic              r_busy;
    logic              r_done;
    logic [SUM_W-1:0]  r_rem;
    logic [RND_W-1:0]  r_quo;
    logic [SUM_W-1:0]  r_div;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W:0]    shifted;
    logic [SUM_W-1:0]  n_rem;

    // The partial remainder stays below the divisor, so the shifted value
    // stays below twice the divisor and one subtract restores it.
    always_comb begin
        shifted = {r_rem, r_quo[RND_W-1]};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = SUM_W'(shifted - {1'b0, r_div});
        end else begin
            n_rem = shifted[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == STEP_W'(RND_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[RND_W-2:0], 1'b0};
            r_cnt <= r_cnt + STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/sorted_book_weighted_probe.sv =====
// Top level of the sorted book weighted probe: command sequencer around the
// book RAM and the serial remainder unit. Uses sbwp_pkg, sbwp_book_ram, sbwp_mod_unit.
//
//  Channel   | Handshake                     | Payload
//  ----------+-------------------------------+------------------------------------
//  command   | start / busy                  | i_cmd, i_entry_*, i_probe_key, i_random_value
//  config    | i_cfg_valid / o_cfg_ready     | i_cfg_data (valid entry count)
//  result    | o_strobe (one cycle)          | o_found, o_chosen_move, o_match_count
//
// A write transaction completes in the cycle it is taken; busy stays low.
// A probe binary-searches the lower bound, scans the run of matching entries (up to
// MAX_RUN), then for a nonzero total weight takes the serial remainder and walks the run
// in the pick pass, else takes its first entry; the single-read-port book RAM sets the pace.
// Reset is synchronous and needs no clearing pass. The result receiver cannot stall.
module sorted_book_weighted_probe
    import sbwp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [IDX_W-1:0]    i_entry_index,
    input  logic [KEY_W-1:0]    i_entry_key,
    input  logic [MOVE_W-1:0]   i_entry_move,
    input  logic [WEIGHT_W-1:0] i_entry_weight,
    input  logic [KEY_W-1:0]    i_probe_key,
    input  logic [RND_W-1:0]    i_random_value,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output logic                o_strobe,
    output logic                o_found,
    output logic [MOVE_W-1:0]   o_chosen_move,
    output logic [RUN_W-1:0]    o_match_count
);

    t_state r_state, n_state;
    logic [CFG_W-1:0]  r_table_len;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [RND_W-1:0]  r_rnd, n_rnd;
    logic [SIZE_W-1:0] r_n, n_n;
    logic [SIZE_W-1:0] r_lo, n_lo;
    logic [SIZE_W-1:0] r_hi, n_hi;
    logic [RUN_W-1:0]  r_run, n_run;
    logic [RUN_W-1:0]  r_k, n_k;
    logic [SUM_W-1:0]  r_total, n_total;
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [SUM_W-1:0]  r_rem, n_rem;
    logic              r_strobe, n_strobe;
    logic              r_found, n_found;
    logic [MOVE_W-1:0] r_move, n_move;
    logic [RUN_W-1:0]  r_count, n_count;

    t_ram_wr ram_wr;
    t_ram_rd ram_rd;
    t_entry  rd_data;

    logic              mod_start;
    logic              mod_done;
    logic [SUM_W-1:0]  mod_rem;
    logic [SIZE_W-1:0] size_clamped;
    logic [SIZE_W:0]   mid_sum;
    logic [SIZE_W-1:0] mid;
    logic [SIZE_W-1:0] scan_pos;
    logic [SIZE_W-1:0] pick_pos;
    logic [SUM_W-1:0]  acc_sum;

    sbwp_book_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd      (ram_rd),
        .o_rd_data (rd_data)
    );

    sbwp_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_total),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    always_comb begin
        if (SIZE_W'(r_table_len) > SIZE_W'(BOOK_DEPTH)) begin
            size_clamped = SIZE_W'(BOOK_DEPTH);
        end else begin
            size_clamped = SIZE_W'(r_table_len);
        end
    end

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = mid_sum[SIZE_W:1];
    assign scan_pos = r_lo + SIZE_W'(r_run);
    assign pick_pos = r_lo + SIZE_W'(r_k);
    assign acc_sum  = r_acc + SUM_W'(rd_data.weight);

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_rnd     = r_rnd;
        n_n       = r_n;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_run     = r_run;
        n_k       = r_k;
        n_total   = r_total;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_strobe  = 1'b0;
        n_found   = r_found;
        n_move    = r_move;
        n_count   = r_count;
        mod_start = 1'b0;

        ram_wr.en          = 1'b0;
        ram_wr.addr        = i_entry_index;
        ram_wr.data.key    = i_entry_key;
        ram_wr.data.move   = i_entry_move;
        ram_wr.data.weight = i_entry_weight;
        ram_rd.en          = 1'b0;
        ram_rd.addr        = mid[IDX_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd == CMD_WRITE) begin
                        ram_wr.en = 1'b1;
                    end else begin
                        n_key   = i_probe_key;
                        n_rnd   = i_random_value;
                        n_n     = size_clamped;
                        n_lo    = '0;
                        n_hi    = size_clamped;
                        n_run   = '0;
                        n_total = '0;
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_lo < r_hi) begin
                    ram_rd.en   = 1'b1;
                    ram_rd.addr = mid[IDX_W-1:0];
                    n_state     = ST_SEARCH_CMP;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SEARCH_CMP: begin
                if (r_key <= rd_data.key) begin
                    n_hi = mid;
                end else begin
                    n_lo = mid + SIZE_W'(1);
                end
                n_state = ST_SEARCH;
            end
            ST_SCAN: begin
                if (r_run < RUN_W'(MAX_RUN) && scan_pos < r_n) begin
                    ram_rd.en   = 1'b1;
                    ram_rd.addr = scan_pos[IDX_W-1:0];
                    n_state     = ST_SCAN_CMP;
                end else if (r_run == '0) begin
                    // Lower bound ran past the table: nothing matched.
                    n_strobe = 1'b1;
                    n_found  = 1'b0;
                    n_move   = '0;
                    n_count  = '0;
                    n_state  = ST_IDLE;
                end else if (r_total == '0) begin
                    n_state = ST_FIRST;
                end else begin
                    mod_start = 1'b1;
                    n_state   = ST_MOD;
                end
            end
            ST_SCAN_CMP: begin
                if (rd_data.key == r_key) begin
                    n_total = r_total + SUM_W'(rd_data.weight);
                    n_run   = r_run + RUN_W'(1);
                    n_state = ST_SCAN;
                end else if (r_run == '0) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b0;
                    n_move   = '0;
                    n_count  = '0;
                    n_state  = ST_IDLE;
                end else if (r_total == '0) begin
                    n_state = ST_FIRST;
                end else begin
                    mod_start = 1'b1;
                    n_state   = ST_MOD;
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_rem   = mod_rem;
                    n_k     = '0;
                    n_acc   = '0;
                    n_state = ST_PICK;
                end
            end
            ST_PICK: begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = pick_pos[IDX_W-1:0];
                n_state     = ST_PICK_CMP;
            end
            ST_PICK_CMP: begin
                n_acc = acc_sum;
                // The remainder is below the run's total, so some entry of
                // the run always takes the pick; the last one is a backstop.
                if (r_rem < acc_sum || r_k == r_run - RUN_W'(1)) begin
                    n_strobe = 1'b1;
                    n_found  = 1'b1;
                    n_move   = rd_data.move;
                    n_count  = r_run;
                    n_state  = ST_IDLE;
                end else begin
                    n_k     = r_k + RUN_W'(1);
                    n_state = ST_PICK;
                end
            end
            ST_FIRST: begin
                ram_rd.en   = 1'b1;
                ram_rd.addr = r_lo[IDX_W-1:0];
                n_state     = ST_FIRST_CMP;
            end
            ST_FIRST_CMP: begin
                n_strobe = 1'b1;
                n_found  = 1'b1;
                n_move   = rd_data.move;
                n_count  = r_run;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_table_len <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_rnd   <= n_rnd;
        r_n     <= n_n;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_run   <= n_run;
        r_k     <= n_k;
        r_total <= n_total;
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_found <= n_found;
        r_move  <= n_move;
        r_count <= n_count;
    end

    assign o_strobe      = r_strobe;
    assign o_found       = r_found;
    assign o_chosen_move = r_move;
    assign o_match_count = r_count;

endmodule
